>>> design/ile_pkg.sv
`default_nettype none

package ile_pkg;

  // list geometry
  localparam int DEPTH     = 256;
  localparam int WORD_BITS = 32;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  // fixed field widths
  localparam int CMD_BITS  = 3;
  localparam int IDX_BITS  = 8;
  localparam int VAL_BITS  = 32;
  localparam int STS_BITS  = 2;
  localparam int LEN_BITS  = 9;

  // width that holds both an index and a count for compares
  localparam int POS_BITS  = (CNT_BITS > IDX_BITS) ? CNT_BITS : IDX_BITS;

  // read gather tree: first level ORs GROUP taps, second level ORs the groups
  localparam int GROUP     = 16;
  localparam int NGROUPS   = (DEPTH + GROUP - 1) / GROUP;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_POP_BACK   = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_REMOVE     = 3'd5,
    CMD_GET        = 3'd6,
    CMD_SET        = 3'd7
  } cmd_t;

  localparam logic [STS_BITS-1:0] STS_OK    = 2'd0;
  localparam logic [STS_BITS-1:0] STS_RANGE = 2'd1;
  localparam logic [STS_BITS-1:0] STS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CK_NONE,
    CK_WRITE,
    CK_OPEN,
    CK_CLOSE
  } cell_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_GATHER
  } state_t;

  typedef logic [WORD_BITS-1:0] word_t;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_kind_t          kind;
    logic [POS_BITS-1:0] pos;
    logic [POS_BITS-1:0] rpos;
    word_t               val;
  } cell_ctrl_t;

  typedef struct packed {
    logic [CMD_BITS-1:0]        command;
    logic [IDX_BITS-1:0]        index;
    logic signed [VAL_BITS-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [STS_BITS-1:0]        status;
    logic signed [VAL_BITS-1:0] read_value;
    logic [LEN_BITS-1:0]        length;
  } out_word_t;

endpackage

`default_nettype wire

>>> design/ile_cell.sv
`default_nettype none

module ile_cell (
  input  wire logic                         clk,
  input  wire logic [ile_pkg::POS_BITS-1:0] cell_idx,
  input  wire ile_pkg::cell_ctrl_t          ctrl,
  input  wire ile_pkg::word_t               prev_word,
  input  wire ile_pkg::word_t               next_word,
  output ile_pkg::word_t                    word,
  output ile_pkg::word_t                    tap
);

  ile_pkg::word_t word_r;
  ile_pkg::word_t word_nxt;

  // pick the new content: hold, load, or take a neighbor's word
  always_comb begin
    word_nxt = word_r;
    unique case (ctrl.kind)
      ile_pkg::CK_WRITE: begin
        if (cell_idx == ctrl.pos) word_nxt = ctrl.val;
      end
      ile_pkg::CK_OPEN: begin
        if (cell_idx == ctrl.pos) word_nxt = ctrl.val;
        else if (cell_idx > ctrl.pos) word_nxt = prev_word;
      end
      ile_pkg::CK_CLOSE: begin
        if (cell_idx >= ctrl.pos) word_nxt = next_word;
      end
      ile_pkg::CK_NONE: begin
        word_nxt = word_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;
  // present the stored word only when this cell is the read target
  assign tap  = (cell_idx == ctrl.rpos) ? word_r : '0;

endmodule

`default_nettype wire

>>> design/ile_gather.sv
`default_nettype none

module ile_gather (
  input  wire logic                                            clk,
  input  wire logic                                            capture,
  input  wire logic [ile_pkg::DEPTH-1:0][ile_pkg::WORD_BITS-1:0] taps,
  output ile_pkg::word_t                                       rd
);

  ile_pkg::word_t grp_r   [ile_pkg::NGROUPS];
  ile_pkg::word_t grp_nxt [ile_pkg::NGROUPS];

  // first level: OR each group of taps (at most one tap is nonzero)
  always_comb begin
    for (int g = 0; g < ile_pkg::NGROUPS; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < ile_pkg::GROUP; k++) begin
        if (g * ile_pkg::GROUP + k < ile_pkg::DEPTH) begin
          grp_nxt[g] = grp_nxt[g] | taps[g * ile_pkg::GROUP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      for (int g = 0; g < ile_pkg::NGROUPS; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  // second level: OR the registered groups
  always_comb begin
    rd = '0;
    for (int g = 0; g < ile_pkg::NGROUPS; g++) begin
      rd = rd | grp_r[g];
    end
  end

endmodule

`default_nettype wire

>>> design/indexed_list_engine.sv
// Channel  Direction  Handshake            Word
// in_      input      in_valid / in_stall  command, index, value
// out_     output     out_valid/out_stall  status, read_value, length
//
// Each command runs through decode, an update of the cell row (on an insert
// or remove every later element shifts one place in that update), and the
// two-level read gather tree. A new word is taken only while the engine is
// idle; the result register lets the next command start while a result waits.
// Reset clears the length and the handshake state; the element cells are not
// reset and are read only after being written. A stalled result holds the
// engine in its gather step until the result register frees up.
`default_nettype none

module indexed_list_engine (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ile_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ile_pkg::out_word_t      out_data
);

  ile_pkg::state_t                state_r, state_nxt;
  logic [ile_pkg::CNT_BITS-1:0]   count_r, count_nxt;
  ile_pkg::cell_ctrl_t            ctrl_r, ctrl_nxt, ctrl_eff;
  logic                           rd_en_r, rd_en_nxt;
  logic [ile_pkg::STS_BITS-1:0]   status_r, status_nxt;
  logic                           out_valid_r;
  ile_pkg::out_word_t             out_r;
  logic                           in_take;
  logic                           out_load;
  logic                           capture;
  ile_pkg::word_t                 rd;

  logic [ile_pkg::POS_BITS-1:0]   idx_ext;
  logic [ile_pkg::POS_BITS-1:0]   cnt_ext;
  logic                           idx_ok;
  logic                           empty;
  logic                           full;

  logic [ile_pkg::DEPTH-1:0][ile_pkg::WORD_BITS-1:0] words;
  logic [ile_pkg::DEPTH-1:0][ile_pkg::WORD_BITS-1:0] taps;

  // decode the incoming command against the current length
  always_comb begin
    idx_ext    = ile_pkg::POS_BITS'(in_data.index);
    cnt_ext    = ile_pkg::POS_BITS'(count_r);
    idx_ok     = idx_ext < cnt_ext;
    empty      = count_r == '0;
    full       = count_r == ile_pkg::CNT_BITS'(ile_pkg::DEPTH);
    ctrl_nxt.kind = ile_pkg::CK_NONE;
    ctrl_nxt.pos  = idx_ext;
    ctrl_nxt.rpos = idx_ext;
    ctrl_nxt.val  = ile_pkg::WORD_BITS'(in_data.value);
    rd_en_nxt     = 1'b0;
    status_nxt    = ile_pkg::STS_OK;
    count_nxt     = count_r;
    unique case (ile_pkg::cmd_t'(in_data.command))
      ile_pkg::CMD_PUSH_BACK: begin
        if (full) status_nxt = ile_pkg::STS_FULL;
        else begin
          ctrl_nxt.kind = ile_pkg::CK_WRITE;
          ctrl_nxt.pos  = cnt_ext;
          count_nxt     = count_r + 1'b1;
        end
      end
      ile_pkg::CMD_POP_BACK: begin
        if (empty) status_nxt = ile_pkg::STS_RANGE;
        else begin
          ctrl_nxt.rpos = cnt_ext - 1'b1;
          rd_en_nxt     = 1'b1;
          count_nxt     = count_r - 1'b1;
        end
      end
      ile_pkg::CMD_PUSH_FRONT: begin
        if (full) status_nxt = ile_pkg::STS_FULL;
        else begin
          ctrl_nxt.kind = ile_pkg::CK_OPEN;
          ctrl_nxt.pos  = '0;
          count_nxt     = count_r + 1'b1;
        end
      end
      ile_pkg::CMD_POP_FRONT: begin
        if (empty) status_nxt = ile_pkg::STS_RANGE;
        else begin
          ctrl_nxt.kind = ile_pkg::CK_CLOSE;
          ctrl_nxt.pos  = '0;
          ctrl_nxt.rpos = '0;
          rd_en_nxt     = 1'b1;
          count_nxt     = count_r - 1'b1;
        end
      end
      ile_pkg::CMD_INSERT: begin
        if (!idx_ok) status_nxt = ile_pkg::STS_RANGE;
        else if (full) status_nxt = ile_pkg::STS_FULL;
        else begin
          ctrl_nxt.kind = ile_pkg::CK_OPEN;
          count_nxt     = count_r + 1'b1;
        end
      end
      ile_pkg::CMD_REMOVE: begin
        if (!idx_ok) status_nxt = ile_pkg::STS_RANGE;
        else begin
          ctrl_nxt.kind = ile_pkg::CK_CLOSE;
          rd_en_nxt     = 1'b1;
          count_nxt     = count_r - 1'b1;
        end
      end
      ile_pkg::CMD_GET: begin
        if (!idx_ok) status_nxt = ile_pkg::STS_RANGE;
        else rd_en_nxt = 1'b1;
      end
      ile_pkg::CMD_SET: begin
        if (!idx_ok) status_nxt = ile_pkg::STS_RANGE;
        else ctrl_nxt.kind = ile_pkg::CK_WRITE;
      end
    endcase
  end

  // next state and handshake controls
  always_comb begin
    state_nxt = state_r;
    in_take   = 1'b0;
    capture   = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ile_pkg::ST_IDLE: begin
        in_take = in_valid;
        if (in_valid) state_nxt = ile_pkg::ST_EXEC;
      end
      ile_pkg::ST_EXEC: begin
        capture   = 1'b1;
        state_nxt = ile_pkg::ST_GATHER;
      end
      ile_pkg::ST_GATHER: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ile_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ile_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ile_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_take) count_r <= count_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // hold the decoded command for the row update and the result
  always_ff @(posedge clk) begin
    if (in_take) begin
      ctrl_r          <= ctrl_nxt;
      rd_en_r         <= rd_en_nxt;
      status_r        <= status_nxt;
    end
    if (out_load) begin
      out_r.status     <= status_r;
      out_r.read_value <= rd_en_r ? ile_pkg::VAL_BITS'(rd) : '0;
      out_r.length     <= ile_pkg::LEN_BITS'(count_r);
    end
  end

  // the row moves only in the update cycle
  always_comb begin
    ctrl_eff = ctrl_r;
    if (state_r != ile_pkg::ST_EXEC) ctrl_eff.kind = ile_pkg::CK_NONE;
  end

  // row of element cells, each linked to its neighbors (an end cell to itself on its open side)
  for (genvar i = 0; i < ile_pkg::DEPTH; i++) begin : g_cell
    ile_cell u_cell (
      .clk       (clk),
      .cell_idx  (ile_pkg::POS_BITS'(i)),
      .ctrl      (ctrl_eff),
      .prev_word ((i == 0) ? words[i] : words[(i == 0) ? 0 : i - 1]),
      .next_word ((i == ile_pkg::DEPTH - 1) ? words[i]
                  : words[(i == ile_pkg::DEPTH - 1) ? i : i + 1]),
      .word      (words[i]),
      .tap       (taps[i])
    );
  end

  ile_gather u_gather (
    .clk     (clk),
    .capture (capture),
    .taps    (taps),
    .rd      (rd)
  );

  assign in_stall  = state_r != ile_pkg::ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_take_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ile_pkg::ST_EXEC))
    else $error("accepted word did not start the row update");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ile_pkg::CNT_BITS'(ile_pkg::DEPTH))
    else $error("length beyond list depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ile_pkg::ST_GATHER && out_valid_r && out_stall)
      |=> (state_r == ile_pkg::ST_GATHER))
    else $error("pending result overwritten");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ile_pkg::ST_GATHER && state_nxt == ile_pkg::ST_IDLE) |=> out_valid_r)
    else $error("finished command produced no result");
`endif

endmodule

`default_nettype wire
